// ----- rtl/fcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg: shared types, constants and helpers of the comb reverb
// Widths of samples and gains, register indexes, gain clipping and
// saturation to 16 bits.
// ----------------------------------------------------------------------------
package fcr_pkg;

   localparam int MAX_DELAY_DEF = 4096;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 17;
   localparam int LEN_W    = 13;
   localparam int IDX_W    = 3;
   localparam int DATA_W   = 18;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = 19;
   localparam int MUL_W    = GAIN_W + 1 + DATA_W;
   localparam int SUM_W    = PROD_W + 1;

   localparam logic [GAIN_W-1:0] Q_ONE = GAIN_W'(65536);

   localparam logic [IDX_W-1:0] CSR_DELAY_LENGTH  = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_WET_GAIN      = IDX_W'(1);
   localparam logic [IDX_W-1:0] CSR_MIX_GAIN      = IDX_W'(2);
   localparam logic [IDX_W-1:0] CSR_DECAY_GAIN    = IDX_W'(3);
   localparam logic [IDX_W-1:0] CSR_FEEDBACK_GAIN = IDX_W'(4);

   typedef struct packed {
      logic              en;
      logic [GAIN_W-1:0] gain;
      logic [DATA_W-1:0] data;
   } mul_op_type;

   function automatic logic [GAIN_W-1:0] clip_gain(input logic [GAIN_W-1:0] g);
      return (g > Q_ONE) ? Q_ONE : g;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(32767);
      lo = -SUM_W'(32768);
      if (v > hi) begin
         return SAMPLE_W'(32767);
      end else if (v < lo) begin
         return SAMPLE_W'(-32768);
      end
      return SAMPLE_W'(v);
   endfunction

endpackage

// ----- rtl/feedback_comb_reverb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_comb_reverb: feedback comb filter reverb
// Channel   Direction  Handshake          Word
// req_      in         valid / stall      req_sample_in, signed 16 bits
// rsp_      out        valid / stall      rsp_sample_out, signed 16 bits
// csr_      in         valid / ready      csr_index, csr_data (17 bits)
//
// Each sample runs these steps in order: accept with the delay line read, six
// passes through the one shared multiplier, then write back and result load.
// After reset the delay line is cleared, one entry a cycle, through all
// MAX_DELAY entries; req_stall stays high meanwhile, csr writes are taken.
// A stalled result holds the write back; the next sample is accepted while a
// result waits. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
module feedback_comb_reverb #(
   parameter int MAX_DELAY = fcr_pkg::MAX_DELAY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [fcr_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fcr_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fcr_pkg::IDX_W-1:0]             csr_index,
   input  logic [fcr_pkg::GAIN_W-1:0]            csr_data
);

   localparam int AW = $clog2(MAX_DELAY);
   localparam int LW = AW + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_T, S_A, S_B, S_Y, S_P, S_K, S_W
   } state_type;

   state_type                                state_ff;
   logic [fcr_pkg::LEN_W-1:0]                delay_length_ff;
   logic [fcr_pkg::GAIN_W-1:0]               wet_gain_ff;
   logic [fcr_pkg::GAIN_W-1:0]               mix_gain_ff;
   logic [fcr_pkg::GAIN_W-1:0]               decay_gain_ff;
   logic [fcr_pkg::GAIN_W-1:0]               feedback_gain_ff;
   logic [AW-1:0]                            ptr_ff;
   logic                                     rsp_valid_ff;
   logic signed [fcr_pkg::SAMPLE_W-1:0]      rsp_sample_out_ff;
   logic signed [fcr_pkg::SAMPLE_W-1:0]      x_ff;
   logic signed [fcr_pkg::SAMPLE_W-1:0]      d_ff;
   logic signed [fcr_pkg::DATA_W-1:0]        xt_ff;
   logic signed [fcr_pkg::PROD_W-1:0]        a_ff;
   logic signed [fcr_pkg::SAMPLE_W-1:0]      y_ff;
   logic signed [fcr_pkg::PROD_W-1:0]        rd_ff;

   logic [fcr_pkg::GAIN_W-1:0]               wet;
   logic [fcr_pkg::GAIN_W-1:0]               mix;
   logic [fcr_pkg::GAIN_W-1:0]               decay;
   logic [fcr_pkg::GAIN_W-1:0]               fbk;
   logic [LW-1:0]                            len_used;
   logic [LW-1:0]                            ptr_inc;
   logic [AW-1:0]                            ptr_in;
   logic                                     accept;
   logic                                     wb_go;
   logic                                     clear_busy;
   logic [fcr_pkg::SAMPLE_W-1:0]             rd_data;
   logic signed [fcr_pkg::SAMPLE_W-1:0]      wb_data;
   fcr_pkg::mul_op_type                      mop;
   logic signed [fcr_pkg::PROD_W-1:0]        mul_q;

   assign wet   = fcr_pkg::clip_gain(wet_gain_ff);
   assign mix   = fcr_pkg::clip_gain(mix_gain_ff);
   assign decay = fcr_pkg::clip_gain(decay_gain_ff);
   assign fbk   = fcr_pkg::clip_gain(feedback_gain_ff);

   assign req_stall      = (state_ff != S_IDLE) || clear_busy;
   assign accept         = req_valid && !req_stall;
   assign wb_go          = (state_ff == S_W) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign csr_ready      = 1'b1;
   assign wb_data        = fcr_pkg::sat16(fcr_pkg::SUM_W'(mul_q) + fcr_pkg::SUM_W'(rd_ff));

   always_comb begin
      if (delay_length_ff == '0) begin
         len_used = LW'(1);
      end else if (32'(delay_length_ff) > 32'(MAX_DELAY)) begin
         len_used = LW'(MAX_DELAY);
      end else begin
         len_used = LW'(delay_length_ff);
      end
      ptr_inc = {1'b0, ptr_ff} + LW'(1);
      ptr_in  = (ptr_inc >= len_used) ? '0 : ptr_inc[AW-1:0];
   end

   // multiplier operand per step
   always_comb begin
      mop = '0;
      unique case (state_ff)
         S_T: begin
            mop.en   = 1'b1;
            mop.gain = mix;
            mop.data = fcr_pkg::DATA_W'($signed(rd_data));
         end
         S_A: begin
            mop.en   = 1'b1;
            mop.gain = fcr_pkg::Q_ONE - wet;
            mop.data = fcr_pkg::DATA_W'(x_ff);
         end
         S_B: begin
            mop.en   = 1'b1;
            mop.gain = wet;
            mop.data = xt_ff;
         end
         S_Y: begin
            mop.en   = 1'b1;
            mop.gain = fbk;
            mop.data = fcr_pkg::DATA_W'(d_ff);
         end
         S_P: begin
            mop.en   = 1'b1;
            mop.gain = fcr_pkg::Q_ONE - fbk;
            mop.data = fcr_pkg::DATA_W'(y_ff);
         end
         S_K: begin
            mop.en   = 1'b1;
            mop.gain = decay;
            mop.data = fcr_pkg::DATA_W'(mul_q);
         end
         S_IDLE, S_W: begin
            mop.en = 1'b0;
         end
         default: begin
            mop.en = 1'b0;
         end
      endcase
   end

   fcr_store #(
      .DEPTH      (MAX_DELAY),
      .AW         (AW)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (ptr_ff),
      .rd_data    (rd_data),
      .wr_en      (wb_go),
      .wr_addr    (ptr_ff),
      .wr_data    (wb_data),
      .clear_busy (clear_busy)
   );

   fcr_mul u_mul (
      .clock (clock),
      .op    (mop),
      .q     (mul_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff  <= fcr_pkg::LEN_W'(1);
         wet_gain_ff      <= '0;
         mix_gain_ff      <= '0;
         decay_gain_ff    <= '0;
         feedback_gain_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fcr_pkg::CSR_DELAY_LENGTH:  delay_length_ff  <= csr_data[fcr_pkg::LEN_W-1:0];
            fcr_pkg::CSR_WET_GAIN:      wet_gain_ff      <= csr_data;
            fcr_pkg::CSR_MIX_GAIN:      mix_gain_ff      <= csr_data;
            fcr_pkg::CSR_DECAY_GAIN:    decay_gain_ff    <= csr_data;
            fcr_pkg::CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !wb_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  x_ff     <= req_sample_in;
                  state_ff <= S_T;
               end
            end
            S_T: begin
               d_ff     <= $signed(rd_data);
               state_ff <= S_A;
            end
            S_A: begin
               xt_ff    <= fcr_pkg::DATA_W'(x_ff) + fcr_pkg::DATA_W'(mul_q);
               state_ff <= S_B;
            end
            S_B: begin
               a_ff     <= mul_q;
               state_ff <= S_Y;
            end
            S_Y: begin
               y_ff     <= fcr_pkg::sat16(fcr_pkg::SUM_W'(a_ff) + fcr_pkg::SUM_W'(mul_q));
               state_ff <= S_P;
            end
            S_P: begin
               rd_ff    <= mul_q;
               state_ff <= S_K;
            end
            S_K: begin
               state_ff <= S_W;
            end
            S_W: begin
               if (wb_go) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_sample_out_ff <= y_ff;
                  ptr_ff            <= ptr_in;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      accept |-> !clear_busy)
      else $error("sample accepted during delay line clear");

   a_wb_loads_result: assert property (@(posedge clock) disable iff (reset)
      wb_go |=> rsp_valid_ff && (rsp_sample_out_ff == $past(y_ff)))
      else $error("write back without result load");

   a_ptr_moves_on_wb: assert property (@(posedge clock) disable iff (reset)
      !wb_go |=> $stable(ptr_ff))
      else $error("pointer moved outside write back");

   a_result_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(wb_go))
      else $error("result raised without write back");

endmodule

// ----- rtl/fcr_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_store: delay line memory
// One write and one registered read port; zeroes every entry after reset.
// ----------------------------------------------------------------------------
module fcr_store #(
   parameter int DEPTH = fcr_pkg::MAX_DELAY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [AW-1:0]                    rd_addr,
   output logic [fcr_pkg::SAMPLE_W-1:0]     rd_data,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic [fcr_pkg::SAMPLE_W-1:0]     wr_data,
   output logic                             clear_busy
);

   logic [fcr_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [fcr_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic [AW:0]                  clr_cnt_ff;

   assign clear_busy = (clr_cnt_ff != (AW+1)'(DEPTH));
   assign rd_data    = rd_data_ff;

   // advance the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clear_busy) begin
         clr_cnt_ff <= clr_cnt_ff + (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy) begin
         mem[clr_cnt_ff[AW-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/fcr_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_mul: shared gain multiplier
// Q16 gain times signed data, arithmetic shift right by 16, registered.
// ----------------------------------------------------------------------------
module fcr_mul (
   input  logic                                clock,
   input  fcr_pkg::mul_op_type                 op,
   output logic signed [fcr_pkg::PROD_W-1:0]   q
);

   logic signed [fcr_pkg::MUL_W-1:0]  prod;
   logic signed [fcr_pkg::PROD_W-1:0] q_ff;

   assign prod = $signed({1'b0, op.gain}) * $signed(op.data);
   assign q    = q_ff;

   // hold the product while idle
   always_ff @(posedge clock) begin
      if (op.en) begin
         q_ff <= fcr_pkg::PROD_W'(prod >>> fcr_pkg::FRAC_W);
      end
   end

endmodule
